### design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the substring first-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

	localparam int MAX_LEN_DEF = 128;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [6:0] match_index;
		logic       overflow;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic       text;
		logic [7:0] byte_value;
		logic       last;
		logic       emits;
	} cmd_t;

endpackage

`default_nettype wire

### design/ssm_front.sv
// ----------------------------------------------------------------------------
// ssm_front
// Input stage: accepts items, classifies them and registers the command.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire ssm_pkg::in_item_t item,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready,
	output ssm_pkg::cmd_t         cmd
);

	logic          valid_s1;
	ssm_pkg::cmd_t cmd_s1;
	ssm_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.text       = (item.func == ssm_pkg::FUNC_TEXT);
		cmd_in.byte_value = item.byte_value;
		cmd_in.last       = item.last;
		// only the closing byte of a text produces a result
		cmd_in.emits      = (item.func == ssm_pkg::FUNC_TEXT) && item.last;
	end

	assign item_ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

`default_nettype wire

### design/ssm_queue.sv
// ----------------------------------------------------------------------------
// ssm_queue
// Short command FIFO decoupling the front stage from the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire ssm_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output ssm_pkg::cmd_t      pop_cmd
);

	localparam int QD = ssm_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	ssm_pkg::cmd_t   mem_q [QD];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(QD));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### design/ssm_back.sv
// ----------------------------------------------------------------------------
// ssm_back
// Search engine: pattern and text shift lines, parallel window compare,
// match tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_back #(
	parameter int MAX_LEN = ssm_pkg::MAX_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire ssm_pkg::cmd_t cmd,
	output logic               result_valid,
	input  wire logic          result_ready,
	output ssm_pkg::out_item_t result
);

	localparam int LW = $clog2(MAX_LEN + 1);

	// pat_q[0] holds the newest pattern byte, tw_q[0] the newest text byte,
	// so the newest window lines up with the pattern tap for tap.
	logic [7:0]          pat_q [MAX_LEN];
	logic [7:0]          tw_q  [MAX_LEN];
	logic [7:0]          nw    [MAX_LEN];
	logic [MAX_LEN-1:0]  ok;

	logic [LW-1:0]       plen_q;
	logic                pat_open_q;
	logic                pat_over_q;
	logic [LW-1:0]       tpos_q;
	logic                seen_q;
	logic [6:0]          start_q;
	logic                tover_q;
	logic                res_valid_q;
	ssm_pkg::out_item_t  res_q;

	logic                take;
	logic [LW-1:0]       plen_base;
	logic                pat_room;
	logic                pat_shift;
	logic                room;
	logic [LW-1:0]       tpos_inc;
	logic [LW-1:0]       start_w;
	logic                hit;
	logic                seen_n;
	logic [6:0]          start_n;
	logic                tover_n;
	logic                text_shift;

	assign take      = cmd_valid && (!cmd.emits || !res_valid_q || result_ready);
	assign cmd_ready = take;

	always_comb begin
		nw[0] = cmd.byte_value;
		for (int j = 1; j < MAX_LEN; j++) begin
			nw[j] = tw_q[j-1];
		end
		// taps beyond the pattern length do not count
		for (int j = 0; j < MAX_LEN; j++) begin
			ok[j] = (nw[j] == pat_q[j]) || (LW'(j) >= plen_q);
		end
	end

	always_comb begin
		plen_base  = pat_open_q ? plen_q : '0;
		pat_room   = plen_base < LW'(MAX_LEN);
		pat_shift  = take && !cmd.text && pat_room;

		room       = tpos_q < LW'(MAX_LEN);
		text_shift = take && cmd.text && room;
		tpos_inc   = tpos_q + 1'b1;
		start_w    = tpos_inc - plen_q;
		hit        = room && !seen_q && !pat_over_q && (plen_q != '0) &&
			(tpos_inc >= plen_q) && (&ok);
		seen_n     = seen_q || hit;
		start_n    = hit ? 7'(start_w) : start_q;
		tover_n    = tover_q || !room;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= '0;
			pat_open_q  <= 1'b0;
			pat_over_q  <= 1'b0;
			tpos_q      <= '0;
			seen_q      <= 1'b0;
			start_q     <= '0;
			tover_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take && !cmd.text) begin
				pat_open_q <= !cmd.last;
				if (pat_room) begin
					plen_q     <= plen_base + 1'b1;
					pat_over_q <= pat_open_q ? pat_over_q : 1'b0;
				end else begin
					plen_q     <= plen_base;
					pat_over_q <= 1'b1;
				end
			end else if (take) begin
				pat_open_q <= 1'b0;
				if (cmd.last) begin
					tpos_q      <= '0;
					seen_q      <= 1'b0;
					start_q     <= '0;
					tover_q     <= 1'b0;
					res_valid_q <= 1'b1;
				end else begin
					tpos_q  <= room ? tpos_inc : tpos_q;
					seen_q  <= seen_n;
					start_q <= start_n;
					tover_q <= tover_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pat_shift) begin
			pat_q[0] <= cmd.byte_value;
			for (int j = 1; j < MAX_LEN; j++) begin
				pat_q[j] <= pat_q[j-1];
			end
		end
		if (text_shift) begin
			for (int j = 0; j < MAX_LEN; j++) begin
				tw_q[j] <= nw[j];
			end
		end
		if (take && cmd.emits) begin
			res_q.found       <= seen_n;
			res_q.match_index <= seen_n ? start_n : '0;
			res_q.overflow    <= pat_over_q || tover_n;
		end
	end

endmodule

`default_nettype wire

### design/substring_first_match.sv
// ----------------------------------------------------------------------------
// substring_first_match
// Leftmost substring search over a streamed text against a loaded pattern.
// ----------------------------------------------------------------------------
// Load the pattern as func=0 bytes (last=1 closes it), then stream the text as
// func=1 bytes; the text byte with last=1 returns one result: found, the start
// index of the leftmost occurrence (mod 128) and an overflow flag. The block
// sustains one byte per clock on pattern and text unless a closing text byte
// waits on a result not yet taken; a byte passes through the input register, a
// four-entry command queue and the search engine, which registers the result.
// The rate is set by the search engine, which compares the newest MAX_LEN text
// bytes against the whole pattern combinationally. The pattern stays loaded
// across texts until the next pattern byte after a close starts a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_first_match #(
	parameter int MAX_LEN = ssm_pkg::MAX_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire ssm_pkg::in_item_t item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ssm_pkg::out_item_t     result
);

	logic          f_valid;
	logic          f_ready;
	ssm_pkg::cmd_t f_cmd;
	logic          q_valid;
	logic          q_ready;
	ssm_pkg::cmd_t q_cmd;

	ssm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	ssm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	ssm_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd          (q_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

### tb/substring_first_match_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_first_match_test
// Self-checking bench for the leftmost substring search block. Pattern and
// text bytes are streamed over the input channel with bursty timing. Every
// accepted transfer is run through a software copy of the search. Each result
// transfer is compared field by field with the oldest predicted match report.
// ----------------------------------------------------------------------------

module substring_first_match_test;

	localparam int WINDOW = ssm_pkg::MAX_LEN_DEF;
	localparam int ITEM_BUDGET = 850;

	typedef logic [7:0] byte_q_t[$];

	// search predictor plus the queue of match reports still owed by the block
	class match_tracker;
		logic [7:0]         pat [WINDOW];
		int unsigned        pat_len;
		bit                 pat_open;
		bit                 pat_overlong;
		logic [7:0]         txt [WINDOW];
		int unsigned        txt_pos;
		bit                 seen;
		int unsigned        start;
		bit                 txt_ovf;
		ssm_pkg::out_item_t owed_reports[$];
		int                 fail_count;

		function new();
			foreach (pat[i])
				pat[i] = '0;
			pat_len      = 0;
			pat_open     = 0;
			pat_overlong = 0;
			fail_count   = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (txt[i])
				txt[i] = '0;
			txt_pos = 0;
			seen    = 0;
			start   = 0;
			txt_ovf = 0;
		endfunction

		function bit window_hit(int unsigned base);
			for (int unsigned k = 0; k < pat_len; k++) begin
				if (txt[base + k] != pat[k])
					return 0;
			end
			return 1;
		endfunction

		function void note_byte(ssm_pkg::in_item_t it);
			ssm_pkg::out_item_t rep;
			if (it.func == ssm_pkg::FUNC_PATTERN) begin
				if (!pat_open) begin
					pat_len      = 0;
					pat_overlong = 0;
					pat_open     = 1;
				end
				if (pat_len < WINDOW) begin
					pat[pat_len] = it.byte_value;
					pat_len++;
				end else begin
					pat_overlong = 1;
				end
				if (it.last)
					pat_open = 0;
				return;
			end
			// any text byte closes a pattern left open
			pat_open = 0;
			if (txt_pos < WINDOW) begin
				txt[txt_pos] = it.byte_value;
				txt_pos++;
				if (!seen && !pat_overlong && pat_len > 0 && txt_pos >= pat_len &&
				    window_hit(txt_pos - pat_len)) begin
					seen  = 1;
					start = txt_pos - pat_len;
				end
			end else begin
				txt_ovf = 1;
			end
			if (!it.last)
				return;
			rep.found       = seen;
			rep.match_index = seen ? 7'(start) : 7'd0;
			rep.overflow    = pat_overlong | txt_ovf;
			owed_reports.push_back(rep);
			clear_text();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			fail_count++;
		endtask

		function int pending();
			return owed_reports.size();
		endfunction

		task check_match(ssm_pkg::out_item_t got);
			ssm_pkg::out_item_t want;
			if (owed_reports.size() == 0) begin
				report($sformatf("unexpected result %b/%0d/%b",
					got.found, got.match_index, got.overflow));
				return;
			end
			want = owed_reports.pop_front();
			if (got.found !== want.found)
				report($sformatf("found %b, want %b", got.found, want.found));
			if (got.match_index !== want.match_index)
				report($sformatf("match_index %0d, want %0d",
					got.match_index, want.match_index));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	ssm_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_ready;
	ssm_pkg::out_item_t result;

	match_tracker tracker = new();

	int unsigned bytes_sent;
	int unsigned burst_left;
	int unsigned hold_requests;

	substring_first_match dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4ms;
		$display("TEST FAILED");
		$finish;
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				tracker.check_match(result);
			if (item_valid && item_ready)
				tracker.note_byte(item);
		end
	end

	// receiver: stall pattern is picked at random from four modes; long hold-off on request
	initial begin
		int unsigned cyc;
		int unsigned mode;
		int unsigned holds_served;
		cyc          = 0;
		mode         = 0;
		holds_served = 0;
		result_ready = 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				result_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				cyc++;
				if (cyc % 50 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= (cyc % 4 == 0);
					default: result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [7:0] pick_char(int unsigned alpha);
		if (alpha == 0)
			return 8'($urandom_range(0, 255));
		return 8'(8'h41 + $urandom_range(0, alpha - 1));
	endfunction

	// returns at the edge where the transfer happened, valid still high
	task send_byte(logic f, logic [7:0] v, logic l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		burst_left--;
		item.func       <= f;
		item.byte_value <= v;
		item.last       <= l;
		item_valid      <= 1'b1;
		do @(posedge clk); while (!item_ready);
		bytes_sent++;
	endtask

	task send_seq(logic f, byte_q_t q, bit close);
		foreach (q[i])
			send_byte(f, q[i], close && (i == q.size() - 1));
	endtask

	task drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	initial begin
		byte_q_t     buf_q;
		byte_q_t     cur_pat;
		byte_q_t     ins;
		int unsigned r;
		int unsigned n;
		int unsigned pos;
		int unsigned alpha;
		bit          hold_done;
		bit          drain_done;

		item_valid    = 1'b0;
		item          = '0;
		bytes_sent    = 0;
		burst_left    = 0;
		hold_requests = 0;
		alpha         = 3;
		hold_done     = 0;
		drain_done    = 0;
		do @(posedge clk); while (arst_n !== 1'b1);
		@(posedge clk);

		// text with no pattern ever loaded
		buf_q = {8'h41};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		// zero and all-ones bytes as ordinary characters
		buf_q = {8'h00, 8'hFF};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q = {8'h01, 8'h00, 8'hFF};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		// pattern longer than text
		buf_q = {8'h80, 8'h7F, 8'h80};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q = {8'h80, 8'h7F};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		// pattern left open, closed by the first text byte
		buf_q = {8'h55, 8'hAA};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 0);
		buf_q = {8'h55, 8'hAA, 8'h55};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		buf_q = {8'h01};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q = {8'h02, 8'h01};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		// pattern kept for the next text
		buf_q = {8'h01};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		buf_q = {8'hFE};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q = {8'hFE, 8'hFE};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);

		// highest index, and a text running past the window
		buf_q = {8'h5A};
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q.delete();
		for (int k = 0; k < WINDOW + 2; k++)
			buf_q.push_back((k == WINDOW - 1 || k == WINDOW) ? 8'h5A : 8'h11);
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		// pattern running past the window: flagged on every text until replaced
		buf_q.delete();
		for (int k = 0; k < WINDOW + 2; k++)
			buf_q.push_back(pick_char(2));
		send_seq(ssm_pkg::FUNC_PATTERN, buf_q, 1);
		buf_q = {8'h41, 8'h42, 8'h41};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		buf_q = {8'h41, 8'h41};
		send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
		cur_pat = {8'h41, 8'h42};
		send_seq(ssm_pkg::FUNC_PATTERN, cur_pat, 1);

		while (bytes_sent < ITEM_BUDGET) begin
			if (!hold_done && bytes_sent > 450) begin
				// receiver holds off while single-byte texts keep coming
				hold_requests++;
				for (int k = 0; k < 12; k++)
					send_byte(ssm_pkg::FUNC_TEXT, pick_char(alpha), 1'b1);
				hold_done = 1;
			end
			if (!drain_done && bytes_sent > 650) begin
				drain();
				drain_done = 1;
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				alpha = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 4);
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				cur_pat.delete();
				for (int k = 0; k < n; k++)
					cur_pat.push_back(pick_char(alpha));
				send_seq(ssm_pkg::FUNC_PATTERN, cur_pat, $urandom_range(0, 6) != 0);
			end else if (r < 18) begin
				n = $urandom_range(1, 8);
				buf_q.delete();
				for (int k = 0; k < n; k++)
					buf_q.push_back(pick_char(0));
				send_seq(ssm_pkg::FUNC_TEXT, buf_q, 1);
			end else begin
				n = $urandom_range(1, 20);
				buf_q.delete();
				for (int k = 0; k < n; k++)
					buf_q.push_back(pick_char(alpha));
				if (cur_pat.size() > 0 && $urandom_range(0, 9) < 7) begin
					// sometimes a partial match runs straight into the real one
					ins.delete();
					if (cur_pat.size() > 1 && $urandom_range(0, 1) == 1) begin
						for (int k = 0; k < cur_pat.size() - 1; k++)
							ins.push_back(cur_pat[k]);
					end
					foreach (cur_pat[k])
						ins.push_back(cur_pat[k]);
					pos = $urandom_range(0, n);
					foreach (ins[k])
						buf_q.insert(pos + k, ins[k]);
				end
				send_seq(ssm_pkg::FUNC_TEXT, buf_q, $urandom_range(0, 19) != 0);
			end
		end
		// close any text left open so its report is owed too
		send_byte(ssm_pkg::FUNC_TEXT, pick_char(alpha), 1'b1);

		drain();
		repeat (16) @(posedge clk);
		if (tracker.fail_count == 0 && tracker.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
